/* src/sas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants of the sprite animation sequencer
// Entry layout, command and register codes, reset values and widths.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int unsigned EntriesDef  = 16;
  localparam int unsigned MaxResults  = 16;
  localparam int unsigned CntW        = 5;   // width of the active counts
  localparam int unsigned ClampW      = 7;   // holds any table depth up to 64
  localparam logic [15:0] BaseReset   = 16'd28672;

  // mode bits of an entry
  localparam int unsigned ModeAnim    = 0;
  localparam int unsigned ModeOneShot = 1;
  localparam int unsigned ModeBounce  = 2;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TICK = 2'd1,
    CMD_DRAW = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BASE = 2'd0,
    REG_ANIM = 2'd1,
    REG_SPR  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [7:0]        x;
    logic [7:0]        y;
    logic [7:0]        start;
    logic [7:0]        delay;
    logic [7:0]        frames;
    logic [2:0]        modes;
    logic              enabled;
    logic [7:0]        dcount;
    logic [7:0]        offset;
    logic signed [8:0] frames_left;
    logic              dir_down;
  } entry_t;

endpackage
`default_nettype wire

/* src/sprite_animation_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_animation_sequencer_core: sprite animation table with tick and draw
// Loads entries, steps their animation and emits one draw beat per entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command beat. A load
//   writes its entry in the accept cycle. A tick walks the first
//   active_animated entries (clamped to the table) through one
//   read-modify-write per cycle and holds in_stall_o until the walk is
//   done. A draw walks the first active_sprites entries (at most 16) and
//   sends one beat per entry on the output channel (out_valid_o /
//   out_stall_i); the first beat passes through the table's read register
//   and the output register, then one beat per cycle follows while the
//   receiver does not stall; last_o marks the final one. Both walks are
//   paced by the single read port of the entry table. Commands are taken
//   one at a time; a new command is taken while the final draw beat still
//   waits in the output register. A receiver stall freezes the draw walk.
//   Reset empties the table (every entry reads as zero, disabled) at once,
//   with no clearing pass, and restores the register defaults. Configuration
//   writes (cfg_we_i) are taken in any cycle.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer_core
  import sas_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_wdata_i,
  // command channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [3:0]        entry_index_i,
  input  wire logic signed [7:0] xpos_i,
  input  wire logic signed [7:0] ypos_i,
  input  wire logic [7:0]        start_sprite_i,
  input  wire logic [7:0]        frame_delay_i,
  input  wire logic [7:0]        sprite_count_i,
  input  wire logic              animated_i,
  input  wire logic              one_shot_i,
  input  wire logic              bounce_i,
  input  wire logic              enable_i,
  input  wire logic              reverse_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [15:0]            screen_address_o,
  output logic [7:0]             sprite_number_o,
  output logic                   visible_o,
  output logic [3:0]             result_index_o,
  output logic                   last_o
);

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_DRAW = 3'b100
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0]     base_q;
  logic [CntW-1:0] anim_q;
  logic [CntW-1:0] spr_q;

  // walk control
  logic [CntW-1:0]  iss_q, iss_d;
  logic [CntW-1:0]  n_q, n_d;
  logic             st1_q;
  logic [AddrW-1:0] st1_addr_q;
  logic             st1_last_q;
  logic [3:0]       st1_idx_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_addr_q;
  logic [7:0]  out_spr_q;
  logic        out_vis_q;
  logic [3:0]  out_idx_q;
  logic        out_last_q;

  logic            in_acc;
  logic            out_free;
  logic            st1_adv;
  logic            issue;
  logic            walk_done;
  logic            load_ok;
  logic [CntW-1:0] n_anim;
  logic [CntW-1:0] n_spr_tbl;
  logic [CntW-1:0] n_spr;

  entry_t           load_e;
  entry_t           rd_e;
  entry_t           tick_e;
  entry_t           wdata;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  logic [15:0] draw_addr;
  logic [7:0]  draw_spr;
  logic        draw_vis;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
      anim_q <= '0;
      spr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE: base_q <= cfg_wdata_i;
        REG_ANIM: anim_q <= cfg_wdata_i[CntW-1:0];
        REG_SPR:  spr_q  <= cfg_wdata_i[CntW-1:0];
        default:  ;  // index beyond the register list: drop
      endcase
    end
  end

  // clamp the walk lengths to the table, and a draw to the result limit
  assign n_anim    = ({2'b00, anim_q} > ClampW'(Entries)) ? CntW'(Entries) : anim_q;
  assign n_spr_tbl = ({2'b00, spr_q} > ClampW'(Entries)) ? CntW'(Entries) : spr_q;
  assign n_spr     = (n_spr_tbl > CntW'(MaxResults)) ? CntW'(MaxResults) : n_spr_tbl;

  // ---------------------------------------------------------------------------
  // command acceptance and walk sequencing
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // tick write-back always completes; a draw beat waits for the output slot
  assign st1_adv    = st1_q && ((state_q == S_TICK) || out_free);
  assign issue      = (state_q != S_IDLE) && (iss_q != n_q) && (!st1_q || st1_adv);
  assign walk_done  = (iss_q == n_q) && (!st1_q || st1_adv);
  assign load_ok    = (cmd_i == CMD_LOAD) && ({3'b000, entry_index_i} < ClampW'(Entries));

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    n_d     = n_q;
    case (state_q)
      S_IDLE: begin
        iss_d = '0;
        if (in_acc && (cmd_i == CMD_TICK) && (n_anim != '0)) begin
          state_d = S_TICK;
          n_d     = n_anim;
        end else if (in_acc && (cmd_i == CMD_DRAW) && (n_spr != '0)) begin
          state_d = S_DRAW;
          n_d     = n_spr;
        end
      end
      S_TICK, S_DRAW: begin
        if (issue) begin
          iss_d = iss_q + CntW'(1);
        end
        if (walk_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      n_q     <= '0;
      st1_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      n_q     <= n_d;
      if (issue) begin
        st1_q <= 1'b1;
      end else if (st1_adv) begin
        st1_q <= 1'b0;
      end
    end
  end

  // track which entry sits in the table's read register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      st1_addr_q <= raddr;
      st1_idx_q  <= iss_q[3:0];
      st1_last_q <= ((iss_q + CntW'(1)) == n_q);
    end
  end

  // ---------------------------------------------------------------------------
  // entry table: a load writes directly, a tick writes back the stepped entry
  // ---------------------------------------------------------------------------
  assign load_e = '{
    x:           xpos_i,
    y:           ypos_i,
    start:       start_sprite_i,
    delay:       frame_delay_i,
    frames:      sprite_count_i,
    modes:       {bounce_i, one_shot_i, animated_i},
    enabled:     enable_i,
    dcount:      frame_delay_i,
    offset:      8'd0,
    frames_left: $signed({1'b0, sprite_count_i}),
    dir_down:    reverse_i
  };

  assign raddr = AddrW'(iss_q);
  assign we    = (in_acc && load_ok) || (st1_q && (state_q == S_TICK));
  assign waddr = (state_q == S_IDLE) ? AddrW'(entry_index_i) : st1_addr_q;
  assign wdata = (state_q == S_IDLE) ? load_e : tick_e;

  sas_table #(
    .Entries (Entries),
    .AddrW   (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .ren_i   (issue),
    .raddr_i (raddr),
    .rdata_o (rd_e)
  );

  sas_tick u_tick (
    .e_i (rd_e),
    .e_o (tick_e)
  );

  sas_draw u_draw (
    .e_i       (rd_e),
    .base_i    (base_q),
    .addr_o    (draw_addr),
    .sprite_o  (draw_spr),
    .visible_o (draw_vis)
  );

  // ---------------------------------------------------------------------------
  // output register: load a draw beat when the slot frees, hold under stall
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st1_adv && (state_q == S_DRAW)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st1_adv && (state_q == S_DRAW)) begin
      out_addr_q <= draw_addr;
      out_spr_q  <= draw_spr;
      out_vis_q  <= draw_vis;
      out_idx_q  <= st1_idx_q;
      out_last_q <= st1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign screen_address_o = out_addr_q;
  assign sprite_number_o  = out_spr_q;
  assign visible_o        = out_vis_q;
  assign result_index_o   = out_idx_q;
  assign last_o           = out_last_q;

`ifndef NO_ASSERTIONS
  // a new command never lands while an entry is still in flight
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !st1_q)
    else $error("command taken with an entry still in flight");

  // the issue counter never runs past the walk length
  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= n_q)
    else $error("issue counter beyond walk length");

  // read and write-back of one walk never hit the same entry together
  a_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && we) |-> (raddr != waddr))
    else $error("read and write to the same entry in one cycle");

  // a draw beat is never loaded over one that is stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(st1_adv && (state_q == S_DRAW)))
    else $error("stalled draw beat overwritten");
`endif

endmodule
`default_nettype wire

/* src/sas_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_table: entry store
// One write port, one registered read port; valid bits make a fresh entry
// read as all zero.
// ----------------------------------------------------------------------------
module sas_table
  import sas_pkg::*;
#(
  parameter int unsigned Entries = EntriesDef,
  parameter int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic             ren_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output entry_t                rdata_o
);

  entry_t             mem [Entries];
  entry_t             rd_q;
  logic               rd_vld_q;
  logic [Entries-1:0] vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ren_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (ren_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  // never-written entries read as their reset value
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

/* src/sas_tick.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_tick: animation step of one entry
// Count down the delay, step the frame, handle the end of a run.
// ----------------------------------------------------------------------------
module sas_tick
  import sas_pkg::*;
(
  input  wire entry_t e_i,
  output entry_t      e_o
);

  logic signed [8:0] fl;

  always_comb begin
    e_o = e_i;
    fl  = e_i.frames_left;
    if (e_i.dcount != 8'd0) begin
      e_o.dcount = e_i.dcount - 8'd1;
    end else begin
      e_o.dcount = e_i.delay;
      e_o.offset = e_i.dir_down ? (e_i.offset - 8'd1) : (e_i.offset + 8'd1);
      // saturate at the most negative count
      if (e_i.modes[ModeAnim] && (fl != -9'sd256)) begin
        fl = fl - 9'sd1;
      end
      e_o.frames_left = fl;
      if ((fl < 9'sd1) && e_i.enabled) begin
        if (e_i.modes[ModeOneShot]) begin
          e_o.enabled = 1'b0;
        end else begin
          e_o.frames_left = $signed({1'b0, e_i.frames});
          if (e_i.modes[ModeBounce]) begin
            e_o.dir_down = !e_i.dir_down;
          end else begin
            e_o.offset = 8'd0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/sas_draw.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sas_draw: draw result of one entry
// Screen address, sprite number and on-screen test.
// ----------------------------------------------------------------------------
module sas_draw
  import sas_pkg::*;
(
  input  wire entry_t       e_i,
  input  wire logic [15:0]  base_i,
  output logic      [15:0]  addr_o,
  output logic      [7:0]   sprite_o,
  output logic              visible_o
);

  logic [15:0] row_off;
  logic [15:0] col_off;
  logic        on_screen;

  // row times 32 plus sign-extended column
  assign row_off   = {{3{e_i.y[7]}}, e_i.y, 5'd0};
  assign col_off   = {{8{e_i.x[7]}}, e_i.x};
  assign addr_o    = base_i + row_off + col_off;
  assign sprite_o  = e_i.start + e_i.offset;
  // column 0..31, row 0..63
  assign on_screen = (e_i.x[7:5] == 3'd0) && (e_i.y[7:6] == 2'd0);
  assign visible_o = e_i.enabled && on_screen;

endmodule
`default_nettype wire
